/* rtl/sepf_pkg.sv */
// shared constants and command/status types of the separable 3-tap image filter
`default_nettype none

package sepf_pkg;

  // defaults for the top-level parameters
  localparam int DEF_MAX_ROWS     = 64;
  localparam int DEF_MAX_COLS     = 64;
  localparam int DEF_CHANNEL_BITS = 16;

  // fixed field widths of the item channels and the register port
  localparam int COORD_W    = 6;
  localparam int CHAN_W     = 16;
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  // signed pass accumulator: four full channels plus the bias level fit in 20 bits
  localparam int ACC_W = 20;

  // request types
  localparam logic REQ_WRITE = 1'b0;

  // filter modes
  localparam logic [1:0] MODE_BINOMIAL = 2'd0;
  localparam logic [1:0] MODE_SOBEL_X  = 2'd1;
  localparam logic [1:0] MODE_SOBEL_Y  = 2'd2;

  // register reset values
  localparam logic [1:0]  RST_FILTER_MODE = MODE_BINOMIAL;
  localparam logic [6:0]  RST_FRAME_ROWS  = 7'd64;
  localparam logic [6:0]  RST_FRAME_COLS  = 7'd64;
  localparam logic [15:0] RST_BIAS_LEVEL  = 16'd255;

  // configuration registers
  typedef struct packed {
    logic [1:0]  filter_mode;
    logic [6:0]  frame_rows;
    logic [6:0]  frame_cols;
    logic [15:0] bias_level;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic       capture;
    logic       decode;
    logic       rd_issue;
    logic [1:0] tap_k;
    logic [1:0] tap_t;
    logic       load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_write;
    logic in_range;
    logic slot_free;
  } stat_t;

endpackage

`default_nettype wire

/* rtl/sepf_if.sv */
// valid/ready item channels: request in, filtered pixel out
`default_nettype none

interface sepf_req_if;
  import sepf_pkg::*;

  logic                valid;
  logic                ready;
  logic                req_type;
  logic [COORD_W-1:0]  pix_row;
  logic [COORD_W-1:0]  pix_col;
  logic [CHAN_W-1:0]   in_red;
  logic [CHAN_W-1:0]   in_green;
  logic [CHAN_W-1:0]   in_blue;

  modport source (
    output valid, req_type, pix_row, pix_col, in_red, in_green, in_blue,
    input  ready
  );

  modport sink (
    input  valid, req_type, pix_row, pix_col, in_red, in_green, in_blue,
    output ready
  );
endinterface

interface sepf_res_if;
  import sepf_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] out_red;
  logic [CHAN_W-1:0] out_green;
  logic [CHAN_W-1:0] out_blue;
  logic              range_error;

  modport source (
    output valid, out_red, out_green, out_blue, range_error,
    input  ready
  );

  modport sink (
    input  valid, out_red, out_green, out_blue, range_error,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/sepf_regs.sv */
// configuration registers behind the apb-style port
`default_nettype none

module sepf_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [sepf_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [sepf_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [sepf_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready,
  output sepf_pkg::cfg_t                     cfg
);
  import sepf_pkg::*;

  localparam logic [1:0] REG_FILTER_MODE = 2'd0;
  localparam logic [1:0] REG_FRAME_ROWS  = 2'd1;
  localparam logic [1:0] REG_FRAME_COLS  = 2'd2;
  localparam logic [1:0] REG_BIAS_LEVEL  = 2'd3;

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[3:2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.filter_mode <= RST_FILTER_MODE;
      cfg.frame_rows  <= RST_FRAME_ROWS;
      cfg.frame_cols  <= RST_FRAME_COLS;
      cfg.bias_level  <= RST_BIAS_LEVEL;
    end else if (wr_en) begin
      case (reg_idx)
        REG_FILTER_MODE: cfg.filter_mode <= pwdata[1:0];
        REG_FRAME_ROWS:  cfg.frame_rows  <= pwdata[6:0];
        REG_FRAME_COLS:  cfg.frame_cols  <= pwdata[6:0];
        REG_BIAS_LEVEL:  cfg.bias_level  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // readback
  always_comb begin
    case (reg_idx)
      REG_FILTER_MODE: prdata = APB_DATA_W'(cfg.filter_mode);
      REG_FRAME_ROWS:  prdata = APB_DATA_W'(cfg.frame_rows);
      REG_FRAME_COLS:  prdata = APB_DATA_W'(cfg.frame_cols);
      REG_BIAS_LEVEL:  prdata = APB_DATA_W'(cfg.bias_level);
      default:         prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/sepf_ctrl.sv */
// request sequencer: decode, nine frame reads, pipeline drain, result load
`default_nettype none

module sepf_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  sepf_pkg::stat_t stat,
  output sepf_pkg::cmd_t  cmd
);
  import sepf_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_FETCH  = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_LOAD   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [1:0] tap_k;
  logic [1:0] tap_t;
  logic       drain;

  assign in_ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.capture  = in_valid & in_ready;
    cmd.tap_k    = tap_k;
    cmd.tap_t    = tap_t;
    case (state)
      S_IDLE: begin
        if (cmd.capture) state_next = S_DECODE;
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        if (stat.is_write) state_next = S_IDLE;
        else if (!stat.in_range) state_next = S_LOAD;
        else state_next = S_FETCH;
      end
      S_FETCH: begin
        cmd.rd_issue = 1'b1;
        if (tap_k == 2'd2 && tap_t == 2'd2) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (drain) state_next = S_LOAD;
      end
      S_LOAD: begin
        cmd.load_out = 1'b1;
        if (stat.slot_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state and tap counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      tap_k <= '0;
      tap_t <= '0;
      drain <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DECODE) begin
        tap_k <= '0;
        tap_t <= '0;
        drain <= 1'b0;
      end else if (state == S_FETCH) begin
        if (tap_t == 2'd2) begin
          tap_t <= '0;
          tap_k <= tap_k + 2'd1;
        end else begin
          tap_t <= tap_t + 2'd1;
        end
      end else if (state == S_DRAIN) begin
        drain <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/sepf_datapath.sv */
// frame memory, neighbour addressing, two filter passes per channel and result register
`default_nettype none

module sepf_datapath #(
  parameter int MAX_ROWS     = sepf_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS     = sepf_pkg::DEF_MAX_COLS,
  parameter int CHANNEL_BITS = sepf_pkg::DEF_CHANNEL_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  sepf_pkg::cfg_t                 cfg,
  input  sepf_pkg::cmd_t                 cmd,
  output sepf_pkg::stat_t                stat,
  input  logic                           req_type,
  input  logic [sepf_pkg::COORD_W-1:0]   pix_row,
  input  logic [sepf_pkg::COORD_W-1:0]   pix_col,
  input  logic [sepf_pkg::CHAN_W-1:0]    in_red,
  input  logic [sepf_pkg::CHAN_W-1:0]    in_green,
  input  logic [sepf_pkg::CHAN_W-1:0]    in_blue,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [sepf_pkg::CHAN_W-1:0]    out_red,
  output logic [sepf_pkg::CHAN_W-1:0]    out_green,
  output logic [sepf_pkg::CHAN_W-1:0]    out_blue,
  output logic                           range_error
);
  import sepf_pkg::*;

  localparam int CB     = CHANNEL_BITS;
  localparam int PIX_W  = 3 * CB;
  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int RW     = $clog2(MAX_ROWS);
  localparam int CW     = $clog2(MAX_COLS);
  localparam int SZR_W  = $clog2(MAX_ROWS + 1);
  localparam int SZC_W  = $clog2(MAX_COLS + 1);
  localparam int RC_W   = (SZR_W > 7) ? SZR_W : 7;
  localparam int CC_W   = (SZC_W > 7) ? SZC_W : 7;
  localparam int RX_W   = (RW > COORD_W) ? RW : COORD_W;
  localparam int CX_W   = (CW > COORD_W) ? CW : COORD_W;
  localparam logic signed [ACC_W-1:0] CMAX = ACC_W'((1 << CB) - 1);

  localparam logic [1:0] TAP_LEAD  = 2'd0;
  localparam logic [1:0] TAP_MID   = 2'd1;
  localparam logic [1:0] TAP_TRAIL = 2'd2;

  // one kernel tap: smoothing {1,2,1} or difference {1,0,-1}
  function automatic logic signed [ACC_W-1:0] weight(input logic signed [ACC_W-1:0] v,
                                                     input logic diff,
                                                     input logic [1:0] tap);
    logic signed [ACC_W-1:0] w;
    w = '0;
    case (tap)
      TAP_LEAD:  w = v;
      TAP_MID:   w = diff ? '0 : (v <<< 1);
      TAP_TRAIL: w = diff ? -v : v;
      default:   w = '0;
    endcase
    return w;
  endfunction

  // add bias, divide by 2 or 4 truncating toward zero, clamp to the channel range
  function automatic logic [CB-1:0] pass_res(input logic signed [ACC_W-1:0] acc,
                                             input logic [15:0] bias,
                                             input logic half);
    logic signed [ACC_W-1:0] s;
    logic signed [ACC_W-1:0] rnd;
    logic signed [ACC_W-1:0] t;
    logic signed [ACC_W-1:0] q;
    logic [CB-1:0]           r;
    s   = acc + $signed(ACC_W'(bias));
    rnd = '0;
    if (s[ACC_W-1]) rnd = half ? ACC_W'(1) : ACC_W'(3);
    t = s + rnd;
    q = half ? (t >>> 1) : (t >>> 2);
    if (q[ACC_W-1]) r = '0;
    else if (q > CMAX) r = CMAX[CB-1:0];
    else r = q[CB-1:0];
    return r;
  endfunction

  logic                     req_type_q;
  logic [COORD_W-1:0]       row_q;
  logic [COORD_W-1:0]       col_q;
  logic [PIX_W-1:0]         pix_q;
  logic [RC_W-1:0]          rows_ext;
  logic [RC_W-1:0]          rows_eff;
  logic [RC_W-1:0]          rows_m1;
  logic [CC_W-1:0]          cols_ext;
  logic [CC_W-1:0]          cols_eff;
  logic [CC_W-1:0]          cols_m1;
  logic [RX_W-1:0]          row_x;
  logic [CX_W-1:0]          col_x;
  logic [RW-1:0]            row_i;
  logic [RW-1:0]            row_last;
  logic [RW-1:0]            row_m;
  logic [RW-1:0]            row_p;
  logic [CW-1:0]            col_i;
  logic [CW-1:0]            col_last;
  logic [CW-1:0]            col_m;
  logic [CW-1:0]            col_p;
  logic                     in_range;
  logic                     err_q;
  logic [RW-1:0]            r_idx [3];
  logic [CW-1:0]            c_idx [3];
  logic [ADDR_W-1:0]        wr_addr;
  logic [ADDR_W-1:0]        rd_addr;
  logic                     wr_en;
  logic [PIX_W-1:0]         mem [DEPTH];
  logic [PIX_W-1:0]         mem_q;
  logic                     rd_v;
  logic [1:0]               rd_k;
  logic [1:0]               rd_t;
  logic                     hrow_v;
  logic [1:0]               hrow_k;
  logic                     kh_diff;
  logic                     kv_diff;
  logic                     half;
  logic signed [ACC_W-1:0]  hacc [3];
  logic signed [ACC_W-1:0]  hsum [3];
  logic signed [ACC_W-1:0]  hrow [3];
  logic signed [ACC_W-1:0]  vacc [3];
  logic signed [ACC_W-1:0]  vsum [3];
  logic [CB-1:0]            res [3];
  logic [CB-1:0]            out_ch [3];
  logic                     out_err;
  logic                     load_fire;

  // request capture, channels masked to the stored width
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_type_q <= req_type;
      row_q      <= pix_row;
      col_q      <= pix_col;
      pix_q      <= {in_red[CB-1:0], in_green[CB-1:0], in_blue[CB-1:0]};
    end
  end

  // frame size in use, clamped to 1..max
  always_comb begin
    rows_ext = RC_W'(cfg.frame_rows);
    cols_ext = CC_W'(cfg.frame_cols);
    if (rows_ext == '0) rows_eff = RC_W'(1);
    else if (rows_ext > RC_W'(MAX_ROWS)) rows_eff = RC_W'(MAX_ROWS);
    else rows_eff = rows_ext;
    if (cols_ext == '0) cols_eff = CC_W'(1);
    else if (cols_ext > CC_W'(MAX_COLS)) cols_eff = CC_W'(MAX_COLS);
    else cols_eff = cols_ext;
    rows_m1  = rows_eff - RC_W'(1);
    cols_m1  = cols_eff - CC_W'(1);
    row_last = rows_m1[RW-1:0];
    col_last = cols_m1[CW-1:0];
  end

  // range check and wrapped neighbour coordinates
  always_comb begin
    in_range = (RC_W'(row_q) < rows_eff) && (CC_W'(col_q) < cols_eff);
    row_x    = RX_W'(row_q);
    col_x    = CX_W'(col_q);
    row_i    = row_x[RW-1:0];
    col_i    = col_x[CW-1:0];
    row_m    = (row_i == '0) ? row_last : row_i - RW'(1);
    row_p    = (row_i == row_last) ? '0 : row_i + RW'(1);
    col_m    = (col_i == '0) ? col_last : col_i - CW'(1);
    col_p    = (col_i == col_last) ? '0 : col_i + CW'(1);
  end

  assign stat.is_write  = (req_type_q == REQ_WRITE);
  assign stat.in_range  = in_range;
  assign stat.slot_free = !out_valid || out_ready;

  // neighbour coordinates held for the fetch sequence
  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      r_idx[0] <= row_m;
      r_idx[1] <= row_i;
      r_idx[2] <= row_p;
      c_idx[0] <= col_m;
      c_idx[1] <= col_i;
      c_idx[2] <= col_p;
      err_q    <= !in_range;
    end
  end

  // single-port frame memory, row-major
  assign wr_en   = cmd.decode && stat.is_write && in_range;
  assign wr_addr = ADDR_W'(row_i) * ADDR_W'(MAX_COLS) + ADDR_W'(col_i);
  assign rd_addr = ADDR_W'(r_idx[cmd.tap_k]) * ADDR_W'(MAX_COLS) + ADDR_W'(c_idx[cmd.tap_t]);

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= pix_q;
    if (cmd.rd_issue) mem_q <= mem[rd_addr];
  end

  // tap tags that follow the read data
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v   <= 1'b0;
      hrow_v <= 1'b0;
    end else begin
      rd_v   <= cmd.rd_issue;
      hrow_v <= rd_v && (rd_t == TAP_TRAIL);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      rd_k <= cmd.tap_k;
      rd_t <= cmd.tap_t;
    end
    if (rd_v && rd_t == TAP_TRAIL) hrow_k <= rd_k;
  end

  // kernel selection
  assign kh_diff = (cfg.filter_mode == MODE_SOBEL_X);
  assign kv_diff = (cfg.filter_mode == MODE_SOBEL_Y);
  assign half    = kh_diff | kv_diff;

  // per-channel lanes: horizontal sum, vertical sum, final pass
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      hsum[ch] = ((rd_t == TAP_LEAD) ? '0 : hacc[ch])
               + weight($signed(ACC_W'(mem_q[(2 - ch) * CB +: CB])), kh_diff, rd_t);
      vsum[ch] = ((hrow_k == TAP_LEAD) ? '0 : vacc[ch])
               + weight($signed(ACC_W'(pass_res(hrow[ch], cfg.bias_level, half))),
                        kv_diff, hrow_k);
      res[ch]  = pass_res(vacc[ch], cfg.bias_level, half);
    end
  end

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 3; ch++) begin
      if (rd_v) begin
        if (rd_t == TAP_TRAIL) hrow[ch] <= hsum[ch];
        else hacc[ch] <= hsum[ch];
      end
      if (hrow_v) vacc[ch] <= vsum[ch];
    end
  end

  // result register
  assign load_fire = cmd.load_out && stat.slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_fire) begin
      for (int ch = 0; ch < 3; ch++) begin
        out_ch[ch] <= err_q ? '0 : res[ch];
      end
      out_err <= err_q;
    end
  end

  assign out_red     = CHAN_W'(out_ch[0]);
  assign out_green   = CHAN_W'(out_ch[1]);
  assign out_blue    = CHAN_W'(out_ch[2]);
  assign range_error = out_err;

endmodule

`default_nettype wire

/* rtl/separable_3tap_image_filter.sv */
// top level of the separable 3-tap image filter
// The block holds an RGB frame in a single-port memory of MAX_ROWS*MAX_COLS entries
// (contents undefined until written, no clearing pass) and serves one request item at
// a time. A write item stores one pixel and gives no result. A read item returns the
// filtered pixel (horizontal then vertical 3-tap pass with wrap-around borders, kernel
// by filter_mode) through a decode step, nine frame reads through the single memory
// port, a pipeline drain for the passes and a result load, the next item being taken
// after the load. A read outside the frame in use returns range_error with zero
// channels, going from decode straight to the result load. The result register frees
// the input side while a result waits; a further result waits in the load step until
// the previous one is taken. The user must write registers through the apb port only
// while the block is idle; the block itself does not enforce it.
`default_nettype none

module separable_3tap_image_filter #(
  parameter int MAX_ROWS     = sepf_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS     = sepf_pkg::DEF_MAX_COLS,
  parameter int CHANNEL_BITS = sepf_pkg::DEF_CHANNEL_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  sepf_req_if.sink                        req,
  sepf_res_if.source                      rsp,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sepf_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [sepf_pkg::APB_DATA_W-1:0] pwdata,
  output logic [sepf_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import sepf_pkg::*;

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;
  logic  in_ready;

  // configuration registers
  sepf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer
  sepf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  assign req.ready = in_ready;

  // frame store and filter arithmetic
  sepf_datapath #(
    .MAX_ROWS     (MAX_ROWS),
    .MAX_COLS     (MAX_COLS),
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd         (cmd),
    .stat        (stat),
    .req_type    (req.req_type),
    .pix_row     (req.pix_row),
    .pix_col     (req.pix_col),
    .in_red      (req.in_red),
    .in_green    (req.in_green),
    .in_blue     (req.in_blue),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .out_red     (rsp.out_red),
    .out_green   (rsp.out_green),
    .out_blue    (rsp.out_blue),
    .range_error (rsp.range_error)
  );

endmodule

`default_nettype wire
